[hdl/clt_pkg.sv]
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, token codes and keyword tables for the tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int OUT_LINE_W      = 20;
    localparam int MAX_KEYWORD_LEN = 12;
    localparam int NUM_KW          = 16;
    localparam int MAX_RECS        = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd17;
    localparam logic [4:0] K_INT     = 5'd18;
    localparam logic [4:0] K_FLOAT   = 5'd19;
    localparam logic [4:0] K_STRING  = 5'd20;
    localparam logic [4:0] K_PUNCT0  = 5'd21;
    localparam logic [4:0] K_UNKNOWN = 5'd31;

    typedef struct packed {
        logic       done;
        logic [4:0] kind;
        logic [7:0] data;
    } rec_t;

    typedef struct packed {
        logic [2:0]              cnt;
        rec_t [MAX_RECS-1:0]     recs;
        logic [OUT_LINE_W-1:0]   line;
    } bundle_t;

    function automatic logic [95:0] kw_word(input logic [3:0] k);
        logic [95:0] w;
        case (k)
            4'd0:    w = "struct";
            4'd1:    w = "enum";
            4'd2:    w = "taggedstruct";
            4'd3:    w = "taggedunion";
            4'd4:    w = "block";
            4'd5:    w = "uchar";
            4'd6:    w = "uint";
            4'd7:    w = "ulong";
            4'd8:    w = "char";
            4'd9:    w = "float";
            4'd10:   w = "double";
            4'd11:   w = "sbyte";
            4'd12:   w = "sword";
            4'd13:   w = "slong";
            4'd14:   w = "ubyte";
            default: w = "uword";
        endcase
        return w;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] l;
        case (k)
            4'd0, 4'd10:             l = 4'd6;
            4'd1, 4'd6, 4'd8:        l = 4'd4;
            4'd2:                    l = 4'd12;
            4'd3:                    l = 4'd11;
            default:                 l = 4'd5;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
        logic [95:0] w;
        logic [3:0]  l;
        logic [7:0]  ch;
        w  = kw_word(k);
        l  = kw_len(k);
        ch = 8'd0;
        if (p < l)
            ch = w[(l - 4'd1 - p) * 8 +: 8];
        return ch;
    endfunction

endpackage

[hdl/clt_front.sv]
// ----------------------------------------------------------------------------
// clt_front
// Scanner: one byte a cycle while take is high, produces a bundle of up to four records.
// ----------------------------------------------------------------------------
module clt_front
    import clt_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output logic       push,
    output bundle_t    bundle
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_SIGN, M_INT, M_FRAC, M_EXPS, M_EXPD,
        M_STRING, M_SLASH, M_LINEC, M_BLOCKC
    } mode_t;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    mode_t                mode_reg, mode_next;
    logic [15:0]          cand_reg, cand_next;
    logic [3:0]           len_reg, len_next;
    logic                 flt_reg, flt_next;
    logic                 esc_reg, esc_next;
    logic                 star_reg, star_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [15:0] kw_filter(input logic [15:0] cand,
                                              input logic [3:0] p,
                                              input logic [7:0] c);
        logic [15:0] r;
        logic [7:0]  lc;
        r  = cand;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        for (int k = 0; k < NUM_KW; k++) begin
            if (p >= kw_len(4'(k)) || 32'(p) >= MAX_KEYWORD_LEN || lc != kw_char(4'(k), p))
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [15:0] cand, input logic [3:0] len);
        logic [4:0] kd;
        logic       hit;
        kd  = K_IDENT;
        hit = 1'b0;
        if (32'(len) <= MAX_KEYWORD_LEN) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (!hit && cand[k] && kw_len(4'(k)) == len) begin
                    hit = 1'b1;
                    kd  = 5'(k + 1);
                end
            end
        end
        return kd;
    endfunction

    function automatic logic [4:0] punct_code(input logic [7:0] c);
        logic [4:0] p;
        case (c)
            "{":     p = 5'd0;
            "}":     p = 5'd1;
            "[":     p = 5'd2;
            "]":     p = 5'd3;
            "(":     p = 5'd4;
            ")":     p = 5'd5;
            ";":     p = 5'd6;
            "=":     p = 5'd7;
            ",":     p = 5'd8;
            "*":     p = 5'd9;
            default: p = 5'd31;
        endcase
        return p;
    endfunction

    logic [2:0]          n;
    rec_t [MAX_RECS-1:0] recs;
    logic                rescan;
    logic                inc;
    logic [4:0]          pc;
    logic [4:0]          num_kind;

    always_comb
    begin
        mode_next = mode_reg;
        cand_next = cand_reg;
        len_next  = len_reg;
        flt_next  = flt_reg;
        esc_next  = esc_reg;
        star_next = star_reg;
        n         = 3'd0;
        recs      = '0;
        rescan    = 1'b0;
        inc       = 1'b0;
        pc        = punct_code(char_in);
        num_kind  = flt_reg ? K_FLOAT : K_INT;

        if (end_of_input)
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    recs[n[1:0]] = '{1'b1, ident_kind(cand_reg, len_reg), 8'd0}; n = n + 3'd1;
                end
                M_SIGN:
                begin
                    recs[n[1:0]] = '{1'b1, K_UNKNOWN, 8'd0}; n = n + 3'd1;
                end
                M_INT, M_FRAC, M_EXPS, M_EXPD:
                begin
                    recs[n[1:0]] = '{1'b1, num_kind, 8'd0}; n = n + 3'd1;
                end
                M_STRING:
                begin
                    recs[n[1:0]] = '{1'b1, K_STRING, 8'd0}; n = n + 3'd1;
                end
                M_SLASH:
                begin
                    recs[n[1:0]] = '{1'b0, K_EOF, "/"}; n = n + 3'd1;
                    recs[n[1:0]] = '{1'b1, K_UNKNOWN, 8'd0}; n = n + 3'd1;
                end
                default: ;
            endcase
            recs[n[1:0]] = '{1'b1, K_EOF, 8'd0}; n = n + 3'd1;
            mode_next = M_IDLE;
            cand_next = 16'hFFFF;
            len_next  = 4'd0;
            flt_next  = 1'b0;
            esc_next  = 1'b0;
            star_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                    if (is_letter(char_in) || is_digit(char_in))
                    begin
                        cand_next = kw_filter(cand_reg, len_reg, char_in);
                        len_next  = (len_reg < 4'd15) ? len_reg + 4'd1 : len_reg;
                        recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                    end
                    else
                    begin
                        recs[n[1:0]] = '{1'b1, ident_kind(cand_reg, len_reg), 8'd0};
                        n = n + 3'd1;
                        rescan = 1'b1;
                    end
                M_SIGN:
                    if (is_digit(char_in))
                    begin
                        recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                        mode_next = M_INT;
                    end
                    else
                    begin
                        recs[n[1:0]] = '{1'b1, K_UNKNOWN, 8'd0}; n = n + 3'd1;
                        rescan = 1'b1;
                    end
                M_INT, M_FRAC:
                    if (is_digit(char_in))
                    begin
                        recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                    end
                    else if (char_in == "." && mode_reg == M_INT)
                    begin
                        recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                        flt_next  = 1'b1;
                        mode_next = M_FRAC;
                    end
                    else if (char_in == "e" || char_in == "E")
                    begin
                        recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                        flt_next  = 1'b1;
                        mode_next = M_EXPS;
                    end
                    else
                    begin
                        recs[n[1:0]] = '{1'b1, num_kind, 8'd0}; n = n + 3'd1;
                        rescan = 1'b1;
                    end
                M_EXPS:
                    if (is_digit(char_in) || char_in == "+" || char_in == "-")
                    begin
                        recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                        mode_next = M_EXPD;
                    end
                    else
                    begin
                        recs[n[1:0]] = '{1'b1, num_kind, 8'd0}; n = n + 3'd1;
                        rescan = 1'b1;
                    end
                M_EXPD:
                    if (is_digit(char_in))
                    begin
                        recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                    end
                    else
                    begin
                        recs[n[1:0]] = '{1'b1, num_kind, 8'd0}; n = n + 3'd1;
                        rescan = 1'b1;
                    end
                M_STRING:
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        case (char_in)
                            "n":     recs[n[1:0]] = '{1'b0, K_EOF, 8'd10};
                            "t":     recs[n[1:0]] = '{1'b0, K_EOF, 8'd9};
                            "r":     recs[n[1:0]] = '{1'b0, K_EOF, 8'd13};
                            default: recs[n[1:0]] = '{1'b0, K_EOF, char_in};
                        endcase
                        n = n + 3'd1;
                    end
                    else if (char_in == "\\")
                        esc_next = 1'b1;
                    else if (char_in == "\"")
                    begin
                        recs[n[1:0]] = '{1'b1, K_STRING, 8'd0}; n = n + 3'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                    end
                M_SLASH:
                    if (char_in == "/")
                        mode_next = M_LINEC;
                    else if (char_in == "*")
                    begin
                        mode_next = M_BLOCKC;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        recs[n[1:0]] = '{1'b0, K_EOF, "/"}; n = n + 3'd1;
                        recs[n[1:0]] = '{1'b1, K_UNKNOWN, 8'd0}; n = n + 3'd1;
                        rescan = 1'b1;
                    end
                M_LINEC:
                    if (char_in == "\n")
                    begin
                        inc       = 1'b1;
                        mode_next = M_IDLE;
                    end
                M_BLOCKC:
                    if (star_reg && char_in == "/")
                    begin
                        mode_next = M_IDLE;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        star_next = (char_in == "*");
                        inc       = (char_in == "\n");
                    end
                default:
                    rescan = 1'b1;
            endcase

            if (rescan)
            begin
                mode_next = M_IDLE;
                if (char_in == " " || char_in == "\t" || char_in == "\r")
                    mode_next = M_IDLE;
                else if (char_in == "\n")
                    inc = 1'b1;
                else if (pc != 5'd31)
                begin
                    recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                    recs[n[1:0]] = '{1'b1, K_PUNCT0 + pc, 8'd0}; n = n + 3'd1;
                end
                else if (char_in == "\"")
                begin
                    mode_next = M_STRING;
                    esc_next  = 1'b0;
                end
                else if (char_in == "/")
                    mode_next = M_SLASH;
                else if (is_letter(char_in))
                begin
                    mode_next = M_IDENT;
                    cand_next = kw_filter(16'hFFFF, 4'd0, char_in);
                    len_next  = 4'd1;
                    recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                end
                else if (is_digit(char_in) || char_in == "-")
                begin
                    mode_next = is_digit(char_in) ? M_INT : M_SIGN;
                    flt_next  = 1'b0;
                    recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                end
                else
                begin
                    recs[n[1:0]] = '{1'b0, K_EOF, char_in}; n = n + 3'd1;
                    recs[n[1:0]] = '{1'b1, K_UNKNOWN, 8'd0}; n = n + 3'd1;
                end
            end
        end

        line_next = (inc && line_reg != LINE_MAX) ? line_reg + 1'b1 : line_reg;
    end

    assign push        = take && (n != 3'd0);
    assign bundle.cnt  = n;
    assign bundle.recs = recs;
    assign bundle.line = OUT_LINE_W'(line_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            cand_reg <= 16'hFFFF;
            len_reg  <= 4'd0;
            flt_reg  <= 1'b0;
            esc_reg  <= 1'b0;
            star_reg <= 1'b0;
            line_reg <= LINE_BITS'(1);
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            cand_reg <= cand_next;
            len_reg  <= len_next;
            flt_reg  <= flt_next;
            esc_reg  <= esc_next;
            star_reg <= star_next;
            line_reg <= line_next;
        end
    end

endmodule

[hdl/clt_queue.sv]
// ----------------------------------------------------------------------------
// clt_queue
// Short bundle queue between scanner and record serialiser.
// ----------------------------------------------------------------------------
module clt_queue
    import clt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t wr_bundle,
    output logic    full,
    input  logic    pop,
    output logic    nonempty,
    output bundle_t rd_bundle
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    bundle_t         mem [QUEUE_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;

    assign full      = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign nonempty  = (cnt_reg != '0);
    assign rd_bundle = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (32'(wp_reg) == QUEUE_DEPTH - 1) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (32'(rp_reg) == QUEUE_DEPTH - 1) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

[hdl/clt_back.sv]
// ----------------------------------------------------------------------------
// clt_back
// Record serialiser: unpacks one bundle into words on the output stream.
// ----------------------------------------------------------------------------
module clt_back
    import clt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_nonempty,
    input  bundle_t     q_bundle,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    bundle_t    cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       last;
    logic       load;
    rec_t       rec;

    assign rec      = cur_reg.recs[idx_reg];
    assign last     = ({1'b0, idx_reg} == cur_reg.cnt - 3'd1);
    assign load     = !valid_reg || (m_tready && last);
    assign q_pop    = load && q_nonempty;
    assign m_tvalid = valid_reg;
    assign m_tuser  = rec.done;
    assign m_tlast  = last;
    assign m_tdata  = {7'd0, cur_reg.line, rec.data, rec.kind};

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= q_nonempty;
            idx_reg   <= 2'd0;
        end
        else if (m_tready)
            idx_reg <= idx_reg + 2'd1;
    end

`ifndef NO_ASSERTIONS
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> cur_reg.cnt != 3'd0)
        else $error("empty bundle shown");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> {1'b0, idx_reg} < cur_reg.cnt)
        else $error("record index past bundle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !m_tready |=> valid_reg && $stable(idx_reg))
        else $error("record dropped under stall");
`endif

endmodule

[hdl/config_language_tokenizer.sv]
// ----------------------------------------------------------------------------
// config_language_tokenizer
// Streaming tokenizer for a configuration language.
// ----------------------------------------------------------------------------
// Input stream s_*: one source byte a word in s_tdata[7:0]; s_tlast is the
// end-of-input flag, which closes the pending token and adds an EOF token.
// Output stream m_*: one record a word. m_tuser is 1 for a token-end record
// (kind valid) and 0 for a lexeme byte record. m_tlast marks the last record
// caused by one input word.
// The scanner takes one byte a cycle while s_tready is high; each byte yields
// zero to four records into a two-bundle queue. The serialiser emits one
// record a cycle while m_tready is high, so throughput is one byte a cycle
// while records average at most one per byte, else limited by the output.
// A byte's records are registered in the queue and then in the serialiser.
// Reset returns the scanner to idle between tokens with line count one and
// empties the queue. A stalled receiver holds the current record; the queue
// then fills and s_tready drops until space frees.
// ----------------------------------------------------------------------------
module config_language_tokenizer
    import clt_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // kind[4:0], lexeme_byte[12:5], line_number[32:13]
    output logic        m_tuser,   // token_done
    output logic        m_tlast    // last_of_run
);

    logic    full;
    logic    take;
    logic    push;
    logic    pop;
    logic    nonempty;
    bundle_t wr_bundle;
    bundle_t rd_bundle;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    clt_front #(.LINE_BITS(LINE_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .char_in      (s_tdata),
        .end_of_input (s_tlast),
        .push         (push),
        .bundle       (wr_bundle)
    );

    clt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_bundle (wr_bundle),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .rd_bundle (rd_bundle)
    );

    clt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (nonempty),
        .q_bundle   (rd_bundle),
        .q_pop      (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
